/* hw/rtl/id3v2_text_frame_extractor_assert.svh */
// Assertion helpers for the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ID3V2_TEXT_FRAME_EXTRACTOR_ASSERT_SVH
`define ID3V2_TEXT_FRAME_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define ID3TFE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ID3TFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/id3tfe_pkg.sv */
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Shared types, codes and helper functions of the ID3v2 text frame extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package id3tfe_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0] byte_kind;
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] parse_status;
  } out_item_t;

  // parse_status codes
  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_NO_TAG  = 2'd3;

  // byte_kind codes
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_TITLE  = 2'd1;
  localparam logic [1:0] KIND_ARTIST = 2'd2;
  localparam logic [1:0] KIND_ALBUM  = 2'd3;

  localparam logic [31:0] ID_TITLE  = 32'h5449_5432; // TIT2
  localparam logic [31:0] ID_ARTIST = 32'h5450_4531; // TPE1
  localparam logic [31:0] ID_ALBUM  = 32'h5441_4C42; // TALB

  localparam logic [15:0] MAX_FRAME_RESET = 16'd4096;
  localparam logic [7:0]  FLAG_EXT_HDR    = 8'h40;
  localparam logic [7:0]  FLAG_FOOTER     = 8'h10;
  localparam logic [7:0]  VER_3           = 8'h03;
  localparam logic [7:0]  VER_4           = 8'h04;

  // "ID3" magic, one byte per header position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = 8'h49;
      2'd1:    m = 8'h44;
      2'd2:    m = 8'h33;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Shift one size byte into an accumulator, 7 bits when syncsafe.
  function automatic logic [31:0] size_add(input logic [31:0] acc,
                                           input logic [7:0]  b,
                                           input logic        syncsafe);
    logic [31:0] r;
    if (syncsafe) begin
      r = {acc[24:0], b[6:0]};
    end else begin
      r = {acc[23:0], b};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/id3tfe_parser.sv */
// ----------------------------------------------------------------------------
// id3tfe_parser
// Tag parser state and the per-word step logic; state advances on step_en.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module id3tfe_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire id3tfe_pkg::in_item_t  item,
  input  wire logic [15:0]           max_frame_bytes,
  output id3tfe_pkg::out_item_t      res
);

  localparam logic [2:0] PH_HEADER     = 3'd0;
  localparam logic [2:0] PH_EXT_SIZE   = 3'd1;
  localparam logic [2:0] PH_EXT_SKIP   = 3'd2;
  localparam logic [2:0] PH_FRAME_HDR  = 3'd3;
  localparam logic [2:0] PH_FRAME_BODY = 3'd4;
  localparam logic [2:0] PH_FRAME_SKIP = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;

  logic [2:0]  phase_r, phase_nxt, phase_cur;
  logic [31:0] sc_r, sc_nxt, sc_cur;
  logic [27:0] tr_r, tr_nxt, tr_cur;
  logic [31:0] fl_r, fl_nxt, fl_cur;
  logic [31:0] as_r, as_nxt, as_cur;
  logic [7:0]  ver_r, ver_nxt, ver_cur;
  logic        ext_r, ext_nxt, ext_cur;
  logic        foot_r, foot_nxt, foot_cur;
  logic [1:0]  kind_r, kind_nxt, kind_cur;
  logic        enc_r, enc_nxt, enc_cur;
  logic        found_r, found_nxt, found_cur;
  logic [1:0]  stat_r, stat_nxt, stat_cur;

  logic [7:0]  b;
  logic [3:0]  idx;
  logic        enter;
  logic [27:0] tr_raw;
  logic [27:0] tr_hdr;
  logic [31:0] total;
  logic [31:0] sc_dec;
  logic [1:0]  kind_o;
  logic        fend_o;

  assign b = item.in_byte;

  // file_start restarts from the cleared state before this word is parsed
  always_comb begin
    if (item.file_start) begin
      phase_cur = PH_HEADER;
      sc_cur    = '0;
      tr_cur    = '0;
      fl_cur    = '0;
      as_cur    = '0;
      ver_cur   = '0;
      ext_cur   = 1'b0;
      foot_cur  = 1'b0;
      kind_cur  = id3tfe_pkg::KIND_OTHER;
      enc_cur   = 1'b0;
      found_cur = 1'b0;
      stat_cur  = id3tfe_pkg::ST_PARSING;
    end else begin
      phase_cur = phase_r;
      sc_cur    = sc_r;
      tr_cur    = tr_r;
      fl_cur    = fl_r;
      as_cur    = as_r;
      ver_cur   = ver_r;
      ext_cur   = ext_r;
      foot_cur  = foot_r;
      kind_cur  = kind_r;
      enc_cur   = enc_r;
      found_cur = found_r;
      stat_cur  = stat_r;
    end
  end

  always_comb begin
    phase_nxt = phase_cur;
    sc_nxt    = sc_cur;
    tr_nxt    = tr_cur;
    fl_nxt    = fl_cur;
    as_nxt    = as_cur;
    ver_nxt   = ver_cur;
    ext_nxt   = ext_cur;
    foot_nxt  = foot_cur;
    kind_nxt  = kind_cur;
    enc_nxt   = enc_cur;
    found_nxt = found_cur;
    stat_nxt  = stat_cur;
    enter     = 1'b0;
    kind_o    = id3tfe_pkg::KIND_OTHER;
    fend_o    = 1'b0;
    idx       = sc_cur[3:0];
    tr_raw    = '0;
    tr_hdr    = tr_cur - 28'd10;
    total     = '0;
    sc_dec    = (sc_cur != 32'd0) ? sc_cur - 32'd1 : 32'd0;

    unique case (phase_cur)
      PH_HEADER: begin
        if (idx == 4'd3) ver_nxt = b;
        if (idx == 4'd5) begin
          ext_nxt  = |(b & id3tfe_pkg::FLAG_EXT_HDR);
          foot_nxt = |(b & id3tfe_pkg::FLAG_FOOTER);
        end
        if (idx >= 4'd6) fl_nxt = id3tfe_pkg::size_add(fl_cur, b, 1'b1);
        if (idx < 4'd3 && b != id3tfe_pkg::magic_byte(idx[1:0])) begin
          phase_nxt = PH_DONE;
          stat_nxt  = id3tfe_pkg::ST_NO_TAG;
        end else if (idx < 4'd9) begin
          sc_nxt = sc_cur + 32'd1;
        end else if (ver_cur != id3tfe_pkg::VER_3 && ver_cur != id3tfe_pkg::VER_4) begin
          phase_nxt = PH_DONE;
          stat_nxt  = id3tfe_pkg::ST_NO_TAG;
        end else begin
          tr_raw = fl_nxt[27:0];
          // v2.4 footer present: drop its 10 bytes, floor at zero
          if (ver_cur == id3tfe_pkg::VER_4 && foot_cur) begin
            tr_nxt = (tr_raw >= 28'd10) ? tr_raw - 28'd10 : 28'd0;
          end else begin
            tr_nxt = tr_raw;
          end
          fl_nxt = '0;
          sc_nxt = '0;
          if (ext_cur) begin
            phase_nxt = PH_EXT_SIZE;
          end else begin
            enter = 1'b1;
          end
        end
      end
      PH_EXT_SIZE: begin
        fl_nxt = id3tfe_pkg::size_add(fl_cur, b, ver_cur == id3tfe_pkg::VER_4);
        if (sc_cur[1:0] != 2'd3) begin
          sc_nxt = sc_cur + 32'd1;
        end else begin
          // bytes consumed = size bytes plus skipped body, at least 4
          total  = (fl_nxt >= 32'd4) ? fl_nxt : 32'd4;
          tr_nxt = (total >= {4'd0, tr_cur}) ? 28'd0 : tr_cur - total[27:0];
          if (fl_nxt <= 32'd4) begin
            enter = 1'b1;
          end else begin
            phase_nxt = PH_EXT_SKIP;
            sc_nxt    = fl_nxt - 32'd4;
          end
        end
      end
      PH_EXT_SKIP, PH_FRAME_SKIP: begin
        sc_nxt = sc_dec;
        if (sc_dec == 32'd0) enter = 1'b1;
      end
      PH_FRAME_HDR: begin
        if (idx == 4'd0 && b == 8'd0) begin
          // padding
          phase_nxt = PH_DONE;
          stat_nxt  = found_cur ? id3tfe_pkg::ST_FOUND : id3tfe_pkg::ST_NONE;
        end else begin
          if (idx == 4'd0) begin
            as_nxt = {24'd0, b};
            fl_nxt = '0;
          end else if (idx < 4'd4) begin
            as_nxt = {as_cur[23:0], b};
          end else if (idx < 4'd8) begin
            fl_nxt = id3tfe_pkg::size_add(fl_cur, b, ver_cur == id3tfe_pkg::VER_4);
          end
          if (idx < 4'd9) begin
            sc_nxt = sc_cur + 32'd1;
          end else begin
            tr_nxt = tr_hdr;
            if (fl_cur == 32'd0 || fl_cur > {4'd0, tr_hdr}) begin
              phase_nxt = PH_DONE;
              stat_nxt  = found_cur ? id3tfe_pkg::ST_FOUND : id3tfe_pkg::ST_NONE;
            end else begin
              tr_nxt = tr_hdr - fl_cur[27:0];
              sc_nxt = fl_cur;
              if (fl_cur > {16'd0, max_frame_bytes}) begin
                phase_nxt = PH_FRAME_SKIP;
              end else begin
                priority if (as_cur == id3tfe_pkg::ID_TITLE) begin
                  kind_nxt = id3tfe_pkg::KIND_TITLE;
                end else if (as_cur == id3tfe_pkg::ID_ARTIST) begin
                  kind_nxt = id3tfe_pkg::KIND_ARTIST;
                end else if (as_cur == id3tfe_pkg::ID_ALBUM) begin
                  kind_nxt = id3tfe_pkg::KIND_ALBUM;
                end else begin
                  kind_nxt = id3tfe_pkg::KIND_OTHER;
                end
                if (kind_nxt != id3tfe_pkg::KIND_OTHER) found_nxt = 1'b1;
                enc_nxt   = 1'b0;
                phase_nxt = PH_FRAME_BODY;
              end
            end
          end
        end
      end
      PH_FRAME_BODY: begin
        if (sc_cur == fl_cur) begin
          // first body byte is the text encoding
          enc_nxt = (b == 8'd0 || b == 8'd3) && fl_cur >= 32'd2;
        end else if (kind_cur != id3tfe_pkg::KIND_OTHER && enc_cur) begin
          kind_o = kind_cur;
          fend_o = (sc_cur == 32'd1);
        end
        sc_nxt = sc_dec;
        if (sc_dec == 32'd0) enter = 1'b1;
      end
      default: begin
      end
    endcase

    // next frame header, or finish when too little tag is left
    if (enter) begin
      if (tr_nxt < 28'd10) begin
        phase_nxt = PH_DONE;
        stat_nxt  = found_nxt ? id3tfe_pkg::ST_FOUND : id3tfe_pkg::ST_NONE;
      end else begin
        phase_nxt = PH_FRAME_HDR;
        sc_nxt    = '0;
      end
    end
  end

  always_comb begin
    res.byte_kind    = kind_o;
    res.out_byte     = b;
    res.frame_end    = fend_o;
    res.parse_status = (phase_nxt == PH_DONE) ? stat_nxt : id3tfe_pkg::ST_PARSING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      sc_r    <= '0;
      tr_r    <= '0;
      fl_r    <= '0;
      as_r    <= '0;
      ver_r   <= '0;
      ext_r   <= 1'b0;
      foot_r  <= 1'b0;
      kind_r  <= id3tfe_pkg::KIND_OTHER;
      enc_r   <= 1'b0;
      found_r <= 1'b0;
      stat_r  <= id3tfe_pkg::ST_PARSING;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      sc_r    <= sc_nxt;
      tr_r    <= tr_nxt;
      fl_r    <= fl_nxt;
      as_r    <= as_nxt;
      ver_r   <= ver_nxt;
      ext_r   <= ext_nxt;
      foot_r  <= foot_nxt;
      kind_r  <= kind_nxt;
      enc_r   <= enc_nxt;
      found_r <= found_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/id3v2_text_frame_extractor.sv */
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor
// Streams file bytes through and tags title, artist and album text bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one file byte per word plus a file_start
//   flag that restarts parsing on the first byte of a new file.
//   out_valid/out_ready/out_data return one word per input word: the byte
//   unchanged, its kind (other, title, artist, album), a frame end flag on
//   the last reported byte of a text frame, and the parse status.
//   cfg_wr_en/cfg_wr_data set the largest frame body that is reported;
//   larger frames are skipped. Write it only while the block is idle.
// Data path:
//   An input word waits in the input register until the parser step moves
//   it into the output register, which drives out_data.
//   Throughput is one word per cycle while out_ready stays high.
// Reset and stall:
//   Reset empties both registers, clears the parser and sets the frame
//   limit to 4096. When out_ready is low the result holds, the next word
//   waits in the input register and in_ready stays low while it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module id3v2_text_frame_extractor (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire id3tfe_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output id3tfe_pkg::out_item_t      out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [15:0]           cfg_wr_data
);

  logic                  in_valid_r;
  id3tfe_pkg::in_item_t  in_data_r;
  logic                  out_valid_r;
  id3tfe_pkg::out_item_t out_data_r;
  logic [15:0]           max_frame_r;
  logic                  advance;
  id3tfe_pkg::out_item_t step_res;

  // move a word from the input register to the output register
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  id3tfe_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (advance),
    .item            (in_data_r),
    .max_frame_bytes (max_frame_r),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_frame_r <= id3tfe_pkg::MAX_FRAME_RESET;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) max_frame_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (advance) out_data_r <= step_res;
  end

endmodule

`default_nettype wire

/* hw/rtl/id3tfe_checker.sv */
// ----------------------------------------------------------------------------
// id3tfe_checker
// Port-level checks of the extractor's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "id3v2_text_frame_extractor_assert.svh"

module id3tfe_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire id3tfe_pkg::out_item_t out_data
);

  `ID3TFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  `ID3TFE_ASSERT_IMPL(a_end_has_kind, out_valid && out_data.frame_end, out_data.byte_kind != id3tfe_pkg::KIND_OTHER, "frame end on a byte that is not text")

  `ID3TFE_ASSERT_IMPL(a_text_status, out_valid && out_data.byte_kind != id3tfe_pkg::KIND_OTHER, out_data.parse_status == id3tfe_pkg::ST_PARSING || out_data.parse_status == id3tfe_pkg::ST_FOUND, "text byte with a status that says no frame found")

endmodule

bind id3v2_text_frame_extractor id3tfe_checker u_id3tfe_checker (.*);

`default_nettype wire
